FILE: rtl/core/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types for the PID controller with anti-windup: beat payloads,
// register indexes, item kinds, controller states and datapath commands.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   typedef enum logic [1:0] {
      KIND_STEP       = 2'd0,
      KIND_CLEAR      = 2'd1,
      KIND_PRESET     = 2'd2,
      KIND_PRESET_ERR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      WM_NONE   = 2'd0,
      WM_CALC   = 2'd1,
      WM_HOLD   = 2'd2,
      WM_FILTER = 2'd3
   } wmode_type;

   typedef enum logic [2:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_I       = 3'd1,
      CSR_GAIN_D       = 3'd2,
      CSR_GAIN_AW      = 3'd3,
      CSR_OUT_MIN      = 3'd4,
      CSR_OUT_MAX      = 3'd5,
      CSR_CLAMP_ENABLE = 3'd6,
      CSR_WINDUP_MODE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        dt;
      logic signed [31:0] error_in;
      logic signed [31:0] preset_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] control_out;
      logic               clamped;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_AW_MUL,
      ST_AW_MQ,
      ST_DIFF,
      ST_PROD,
      ST_INTEG_ADD,
      ST_DER_DIV,
      ST_DER_WAIT,
      ST_DER_WR,
      ST_DER_ZERO,
      ST_P_MUL,
      ST_P_MQ,
      ST_P_SAVE,
      ST_D_MUL,
      ST_D_MQ,
      ST_PD,
      ST_I_MUL,
      ST_I_MQ,
      ST_VAL,
      ST_CLAMP,
      ST_WIND,
      ST_AWC_DIV,
      ST_PRE_DIV,
      ST_Q_WAIT,
      ST_INTEG_WR,
      ST_PRESET,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_CLEAR,
      OP_MUL_AW,
      OP_MUL_P,
      OP_MUL_D,
      OP_MUL_I,
      OP_MQ,
      OP_DIFF,
      OP_PROD,
      OP_INTEG_ADD,
      OP_DIV_DERIV,
      OP_DERIV_WR,
      OP_DERIV_ZERO,
      OP_P_SAVE,
      OP_PD,
      OP_VAL,
      OP_CLAMP,
      OP_WIND,
      OP_DIV_AWC,
      OP_DIV_PRESET,
      OP_INTEG_WR,
      OP_PRESET,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type  kind;
      logic      dt_zero;
      logic      gi_zero;
      logic      clamp_en;
      wmode_type wmode;
      logic      div_busy;
      logic      rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/core/pidaw_div.sv
// ----------------------------------------------------------------------------
// pidaw_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidaw_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num_mag,
   input  logic [DEN_W-1:0] den_mag,
   output logic             busy,
   output logic [NUM_W-1:0] quo_mag
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CW-1:0]    cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             ge;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num_mag;
         den_ff <= den_mag;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign busy    = busy_ff;
   assign quo_mag = quo_ff;

endmodule

FILE: rtl/core/pidaw_dp.sv
// ----------------------------------------------------------------------------
// pidaw_dp
// Datapath: configuration registers, controller state, shared fixed-point
// multiplier, serial divider and the result register.
// ----------------------------------------------------------------------------
module pidaw_dp import pidaw_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload,
   input  logic          csr_valid,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int WW    = 72;
   localparam int SPLIT = 24;
   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int DEN_W = 32;

   localparam logic signed [WW-1:0] S32_HI = 72'sd2147483647;
   localparam logic signed [WW-1:0] S32_LO = -72'sd2147483648;
   localparam logic signed [WW-1:0] S48_HI = 72'sd140737488355327;
   localparam logic signed [WW-1:0] S48_LO = -72'sd140737488355328;
   localparam logic signed [WW-1:0] HI_LIM = 72'sd35184372088832;

   function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] x);
      logic signed [WW-1:0] y;
      y = (x > S32_HI) ? S32_HI : ((x < S32_LO) ? S32_LO : x);
      return y[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [WW-1:0] x);
      logic signed [WW-1:0] y;
      y = (x > S48_HI) ? S48_HI : ((x < S48_LO) ? S48_LO : x);
      return y[47:0];
   endfunction

   function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
      logic signed [31:0] r;
      r = (v < lo) ? lo : ((v > hi) ? hi : v);
      return r;
   endfunction

   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff, gain_aw_ff;
   logic signed [31:0] out_min_ff, out_max_ff;
   logic               clamp_en_ff;
   wmode_type          wmode_ff;

   req_type            req_ff;
   logic signed [47:0] integ_ff, old_i_ff;
   logic signed [31:0] last_err_ff, deriv_ff, outr_ff, wdelta_ff;
   logic signed [55:0] ph_ff;
   logic signed [56:0] pl_ff;
   logic signed [64:0] prod_ff;
   logic signed [31:0] mq_ff, diff_ff, p_ff, pd_ff, val_ff, res_ff;
   logic               clamped_ff;
   logic               q_neg_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic signed [31:0] mul_g;
   logic signed [47:0] mul_v;
   logic signed [WW-1:0] mq_t, mq_sum;
   logic signed [WW-1:0] div_num, div_num_abs, q_w;
   logic               div_num_neg, div_den_neg, div_start, div_busy;
   logic [DEN_W-1:0]   div_den;
   logic [32:0]        gi_abs;
   logic [NUM_W-1:0]   quo_mag;
   logic signed [31:0] clamp_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         gain_aw_ff  <= '0;
         out_min_ff  <= 32'sh8000_0000;
         out_max_ff  <= 32'sh7FFF_FFFF;
         clamp_en_ff <= 1'b0;
         wmode_ff    <= WM_NONE;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:       gain_p_ff   <= csr_data;
            CSR_GAIN_I:       gain_i_ff   <= csr_data;
            CSR_GAIN_D:       gain_d_ff   <= csr_data;
            CSR_GAIN_AW:      gain_aw_ff  <= csr_data;
            CSR_OUT_MIN:      out_min_ff  <= csr_data;
            CSR_OUT_MAX:      out_max_ff  <= csr_data;
            CSR_CLAMP_ENABLE: clamp_en_ff <= csr_data[0];
            CSR_WINDUP_MODE:  wmode_ff    <= wmode_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.op)
         OP_MUL_AW: begin
            mul_g = gain_aw_ff;
            mul_v = 48'(wdelta_ff);
         end
         OP_MUL_D: begin
            mul_g = gain_d_ff;
            mul_v = 48'(deriv_ff);
         end
         OP_MUL_I: begin
            mul_g = gain_i_ff;
            mul_v = integ_ff;
         end
         default: begin
            mul_g = gain_p_ff;
            mul_v = 48'(req_ff.error_in);
         end
      endcase
   end

   always_comb begin
      mq_t = WW'(ph_ff);
      if (mq_t > HI_LIM) begin
         mq_t = HI_LIM;
      end else if (mq_t < -HI_LIM) begin
         mq_t = -HI_LIM;
      end
      mq_sum = (mq_t <<< (SPLIT - FRAC_BITS)) + (WW'(pl_ff) >>> FRAC_BITS);
   end

   assign clamp_res = clamp_en_ff ? clampv(val_ff, out_min_ff, out_max_ff) : val_ff;
   assign gi_abs    = gain_i_ff[31] ? -33'(gain_i_ff) : 33'(gain_i_ff);

   always_comb begin
      div_start   = 1'b0;
      div_num     = (WW'(req_ff.error_in) - WW'(last_err_ff)) <<< FRAC_BITS;
      div_den     = req_ff.dt;
      div_den_neg = 1'b0;
      case (cmd.op)
         OP_DIV_DERIV: begin
            div_start = 1'b1;
         end
         OP_DIV_AWC: begin
            div_start   = 1'b1;
            div_num     = (WW'(res_ff) - WW'(clampv(pd_ff, out_min_ff, out_max_ff)))
                          <<< FRAC_BITS;
            div_den     = gi_abs[31:0];
            div_den_neg = gain_i_ff[31];
         end
         OP_DIV_PRESET: begin
            div_start   = 1'b1;
            div_num     = (req_ff.kind == KIND_PRESET) ?
                          (WW'(req_ff.preset_value) <<< FRAC_BITS) :
                          ((WW'(req_ff.preset_value) - WW'(pd_ff)) <<< FRAC_BITS);
            div_den     = gi_abs[31:0];
            div_den_neg = gain_i_ff[31];
         end
         default: ;
      endcase
      div_num_neg = div_num[WW-1];
      div_num_abs = div_num_neg ? -div_num : div_num;
   end

   pidaw_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (div_num_abs[NUM_W-1:0]),
      .den_mag (div_den),
      .busy    (div_busy),
      .quo_mag (quo_mag)
   );

   always_comb begin
      q_w = $signed(WW'(quo_mag));
      if (q_neg_ff) begin
         q_w = -q_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
         deriv_ff    <= '0;
         outr_ff     <= '0;
         wdelta_ff   <= '0;
         clamped_ff  <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               req_ff     <= req_payload;
               clamped_ff <= 1'b0;
            end
            OP_CLEAR: begin
               integ_ff    <= '0;
               last_err_ff <= '0;
               deriv_ff    <= '0;
               outr_ff     <= '0;
               wdelta_ff   <= '0;
            end
            OP_MUL_AW, OP_MUL_P, OP_MUL_D, OP_MUL_I: begin
               ph_ff <= mul_g * $signed(mul_v[47:SPLIT]);
               pl_ff <= mul_g * $signed({1'b0, mul_v[SPLIT-1:0]});
            end
            OP_MQ: mq_ff <= sat32(mq_sum);
            OP_DIFF: diff_ff <= sat32(WW'(req_ff.error_in) - WW'(mq_ff));
            OP_PROD: begin
               prod_ff  <= diff_ff * $signed({1'b0, req_ff.dt});
               old_i_ff <= integ_ff;
            end
            OP_INTEG_ADD: integ_ff <= sat48(WW'(integ_ff) + (WW'(prod_ff) >>> FRAC_BITS));
            OP_DIV_DERIV, OP_DIV_AWC, OP_DIV_PRESET: q_neg_ff <= div_num_neg ^ div_den_neg;
            OP_DERIV_WR: begin
               deriv_ff    <= sat32(q_w);
               last_err_ff <= req_ff.error_in;
            end
            OP_DERIV_ZERO: deriv_ff <= '0;
            OP_P_SAVE: p_ff <= mq_ff;
            OP_PD: pd_ff <= sat32(WW'(p_ff) + WW'(mq_ff));
            OP_VAL: val_ff <= sat32(WW'(pd_ff) + WW'(mq_ff));
            OP_CLAMP: begin
               res_ff     <= clamp_res;
               outr_ff    <= clamp_res;
               clamped_ff <= clamp_en_ff && (clamp_res != val_ff);
            end
            OP_WIND: begin
               if (wmode_ff == WM_HOLD && clamped_ff) begin
                  integ_ff <= old_i_ff;
               end
               if (wmode_ff == WM_FILTER) begin
                  wdelta_ff <= sat32(WW'(val_ff) - WW'(res_ff));
               end
            end
            OP_INTEG_WR: integ_ff <= sat48(q_w);
            OP_PRESET: begin
               if (gain_i_ff == '0) begin
                  integ_ff <= '0;
               end
               outr_ff   <= req_ff.preset_value;
               wdelta_ff <= '0;
               if (req_ff.kind == KIND_PRESET) begin
                  deriv_ff    <= '0;
                  last_err_ff <= '0;
               end else begin
                  last_err_ff <= req_ff.error_in;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESP) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RESP) begin
         rsp_ff.control_out <= outr_ff;
         rsp_ff.clamped     <= clamped_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.kind     = req_ff.kind;
   assign status.dt_zero  = (req_ff.dt == '0);
   assign status.gi_zero  = (gain_i_ff == '0);
   assign status.clamp_en = clamp_en_ff;
   assign status.wmode    = wmode_ff;
   assign status.div_busy = div_busy;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("Divider started while busy.");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESP) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Pending result overwritten.");

   a_rsp_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESP) |=> rsp_valid_ff)
      else $error("Result beat not presented after issue.");

endmodule

FILE: rtl/core/pidaw_ctrl.sv
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer that walks the datapath through one item at a time.
// ----------------------------------------------------------------------------
module pidaw_ctrl import pidaw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.kind)
               KIND_STEP:   state_in = status.dt_zero ? ST_RESP : ST_AW_MUL;
               KIND_CLEAR:  state_in = ST_CLEAR;
               KIND_PRESET: state_in = status.gi_zero ? ST_PRESET : ST_PRE_DIV;
               default:     state_in = status.dt_zero ? ST_DER_ZERO : ST_DER_DIV;
            endcase
         end
         ST_AW_MUL: begin
            cmd.op   = OP_MUL_AW;
            state_in = ST_AW_MQ;
         end
         ST_AW_MQ: begin
            cmd.op   = OP_MQ;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            cmd.op   = OP_PROD;
            state_in = ST_INTEG_ADD;
         end
         ST_INTEG_ADD: begin
            cmd.op   = OP_INTEG_ADD;
            state_in = ST_DER_DIV;
         end
         ST_DER_DIV: begin
            cmd.op   = OP_DIV_DERIV;
            state_in = ST_DER_WAIT;
         end
         ST_DER_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_DER_WR;
            end
         end
         ST_DER_WR: begin
            cmd.op   = OP_DERIV_WR;
            state_in = ST_P_MUL;
         end
         ST_DER_ZERO: begin
            cmd.op   = OP_DERIV_ZERO;
            state_in = ST_P_MUL;
         end
         ST_P_MUL: begin
            cmd.op   = OP_MUL_P;
            state_in = ST_P_MQ;
         end
         ST_P_MQ: begin
            cmd.op   = OP_MQ;
            state_in = ST_P_SAVE;
         end
         ST_P_SAVE: begin
            cmd.op   = OP_P_SAVE;
            state_in = ST_D_MUL;
         end
         ST_D_MUL: begin
            cmd.op   = OP_MUL_D;
            state_in = ST_D_MQ;
         end
         ST_D_MQ: begin
            cmd.op   = OP_MQ;
            state_in = ST_PD;
         end
         ST_PD: begin
            cmd.op = OP_PD;
            if (status.kind == KIND_STEP) begin
               state_in = ST_I_MUL;
            end else begin
               state_in = status.gi_zero ? ST_PRESET : ST_PRE_DIV;
            end
         end
         ST_I_MUL: begin
            cmd.op   = OP_MUL_I;
            state_in = ST_I_MQ;
         end
         ST_I_MQ: begin
            cmd.op   = OP_MQ;
            state_in = ST_VAL;
         end
         ST_VAL: begin
            cmd.op   = OP_VAL;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = status.clamp_en ? ST_WIND : ST_RESP;
         end
         ST_WIND: begin
            cmd.op = OP_WIND;
            if (status.wmode == WM_CALC && !status.gi_zero) begin
               state_in = ST_AWC_DIV;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_AWC_DIV: begin
            cmd.op   = OP_DIV_AWC;
            state_in = ST_Q_WAIT;
         end
         ST_PRE_DIV: begin
            cmd.op   = OP_DIV_PRESET;
            state_in = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_INTEG_WR;
            end
         end
         ST_INTEG_WR: begin
            cmd.op   = OP_INTEG_WR;
            state_in = (status.kind == KIND_STEP) ? ST_RESP : ST_PRESET;
         end
         ST_PRESET: begin
            cmd.op   = OP_PRESET;
            state_in = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.op   = OP_CLEAR;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: rtl/core/pid_controller_anti_windup.sv
// ----------------------------------------------------------------------------
// pid_controller_anti_windup
// Parallel PID controller on signed fixed-point signals with output clamp
// and four anti-windup modes.
// ----------------------------------------------------------------------------
// One item is processed at a time, and a new item is taken while the previous
// result beat still waits. The bit-serial divider holds the sequencer while it
// runs. A step item divides once for the derivative and skips the windup step
// with the clamp disabled. In calculation mode with a nonzero integral gain a
// second divide recomputes the integral. A preset divides once, or not at all
// with a zero integral gain. A preset with error divides twice, one divide
// less with a zero time step or a zero integral gain. A step item with a zero
// time step skips all arithmetic and returns the last output. Signals are
// Q16.16 at the default FRAC_BITS. A stalled result beat holds the next
// result back.
module pid_controller_anti_windup import pidaw_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pidaw_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule
